// ===== src/srne_pkg.sv =====
// Shared types and constants for the sound register to note event decoder.
// Used by srne_div, srne_pat and the top level sound_register_to_note_events.
package srne_pkg;

    localparam int BASE_CLOCK = 3579545;
    localparam int BASE_W = 22;
    localparam int DSR_W = 25;
    localparam int STEP_W = 24;
    localparam int FREQ_W = 26;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    localparam logic [7:0] DIV_SLOW = 8'd56;
    localparam logic [7:0] DIV_15K = 8'd228;
    localparam logic [7:0] DIV_FAST = 8'd2;
    localparam logic [2:0] OFS_NORMAL = 3'd1;
    localparam logic [2:0] OFS_FAST = 3'd4;
    localparam logic [2:0] OFS_JOINED = 3'd7;

    localparam logic [3:0] DIST_ODD = 4'h1;
    localparam logic [3:0] DIST_POLY5 = 4'h2;
    localparam logic [3:0] DIST_PURE = 4'h8;
    localparam logic [3:0] DIST_PURE_A = 4'ha;
    localparam logic [3:0] DIST_POLY4 = 4'hc;

    localparam logic [4:0] LEN_POLY4 = 5'd15;
    localparam logic [4:0] LEN_POLY5 = 5'd31;

    // Output bit sequences of the two polynomial counters, bit i is step i.
    localparam logic [14:0] SEQ_POLY4 = 15'h70a6;
    localparam logic [30:0] SEQ_POLY5 = 31'h7a89_c196;

    typedef struct packed {
        logic [30:0]       pattern_bits;
        logic [4:0]        pattern_length;
        logic [3:0]        distortion;
        logic [3:0]        volume;
        logic [FREQ_W-1:0] frequency_q8;
        logic              hold;
        logic [1:0]        channel;
    } note_event_t;

endpackage

// ===== src/srne_div.sv =====
// Restoring divider producing one quotient bit per cycle.
// Depends on srne_pkg for the divisor width.
module srne_div #(
    parameter int N = 38
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [N-1:0]               dividend,
    input  logic [srne_pkg::DSR_W-1:0] divisor,
    output logic                       done,
    output logic [N-1:0]               quotient,
    output logic [srne_pkg::DSR_W-1:0] remainder
);
    import srne_pkg::*;

    localparam int CNT_W = $clog2(N + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [N-1:0]      quo_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DSR_W:0]    trial;
    logic [DSR_W+1:0]  diff;

    assign trial = {rem_reg, quo_reg[N-1]};
    assign diff = {1'b0, trial} - {2'b00, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
            dsr_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(N);
                quo_reg <= dividend;
                rem_reg <= '0;
                dsr_reg <= divisor;
            end
            else if (busy_reg)
            begin
                if (!diff[DSR_W+1])
                begin
                    rem_reg <= diff[DSR_W-1:0];
                end
                else
                begin
                    rem_reg <= trial[DSR_W-1:0];
                end
                quo_reg <= {quo_reg[N-2:0], ~diff[DSR_W+1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/srne_pat.sv =====
// Walks a polynomial sequence at a given stride and strips trailing zeros.
// Depends on srne_pkg for the sequence tables.
module srne_pat (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        size5,
    input  logic [4:0]  stride,
    output logic        done,
    output logic [30:0] bits
);
    import srne_pkg::*;

    typedef enum logic [1:0] {P_IDLE, P_WALK, P_STRIP} pat_state_t;

    pat_state_t  state_reg;
    logic        done_reg;
    logic        size5_reg;
    logic [4:0]  stride_reg;
    logic [4:0]  pos_reg;
    logic [4:0]  cnt_reg;
    logic [30:0] acc_reg;
    logic [4:0]  len;
    logic        seq_bit;
    logic [5:0]  pos_sum;
    logic [5:0]  pos_wrap;

    assign len = size5_reg ? LEN_POLY5 : LEN_POLY4;
    assign seq_bit = size5_reg ? SEQ_POLY5[pos_reg] : SEQ_POLY4[pos_reg[3:0]];
    assign pos_sum = {1'b0, pos_reg} + {1'b0, stride_reg};
    assign pos_wrap = (pos_sum >= {1'b0, len}) ? pos_sum - {1'b0, len} : pos_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg <= 1'b0;
            size5_reg <= 1'b0;
            stride_reg <= '0;
            pos_reg <= '0;
            cnt_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        size5_reg <= size5;
                        stride_reg <= stride;
                        pos_reg <= '0;
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        state_reg <= P_WALK;
                    end
                end
                P_WALK:
                begin
                    acc_reg <= {acc_reg[29:0], seq_bit};
                    pos_reg <= pos_wrap[4:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == len - 1'b1)
                    begin
                        state_reg <= P_STRIP;
                    end
                end
                P_STRIP:
                begin
                    if (acc_reg != '0 && !acc_reg[0])
                    begin
                        acc_reg <= {1'b0, acc_reg[30:1]};
                    end
                    else
                    begin
                        done_reg <= 1'b1;
                        state_reg <= P_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign bits = acc_reg;

endmodule

// ===== src/sound_register_to_note_events.sv =====
// Sound register snapshot decoder: one snapshot in, zero to four note events out.
// Each snapshot is handled channel by channel; a channel that emits an event uses
// the shared restoring divider for its frequency and, for a polynomial distortion,
// for the stride modulo of the pattern, then walks and trims the pattern.
// The input is not ready while a snapshot is in work; the last event carries tlast.
// Depends on srne_pkg, srne_div and srne_pat.
module sound_register_to_note_events #(
    parameter int FREQ_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // audio_control, divider_ch0..3, channel_ctrl_ch0..3 from the lowest bit up.
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // channel, hold, frequency_q8, volume, distortion, pattern_length, pattern_bits.
    output logic [79:0] m_tdata,
    output logic        m_tlast
);
    import srne_pkg::*;

    localparam int DVD_W = (FREQ_FRAC_BITS + BASE_W > FREQ_W) ?
                           FREQ_FRAC_BITS + BASE_W : FREQ_W;

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_MUL, S_FSTART, S_FWAIT, S_MSTART, S_MWAIT,
        S_PWAIT, S_PUSH, S_END
    } state_t;

    state_t      state_reg;
    logic [71:0] snap_reg;
    logic [1:0]  ch_reg;
    logic [15:0] prev_div_reg [4];
    logic [7:0]  prev_cc_reg [4];
    logic [7:0]  prev_ctl_reg;
    logic [15:0] cdiv_reg;
    logic [2:0]  cm_reg;
    logic [7:0]  cd_reg;
    logic [3:0]  cvol_reg;
    logic [3:0]  cdist_reg;
    logic [4:0]  cplen_reg;
    logic [STEP_W-1:0] step_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [30:0] pbits_reg;
    note_event_t pend_reg;
    logic        pend_valid_reg;
    note_event_t out_reg;
    logic        out_valid_reg;
    logic        out_last_reg;

    logic [7:0]  ctl;
    logic [7:0]  dv [4];
    logic [7:0]  cc [4];
    logic [7:0]  dd [4];
    logic [2:0]  mm [4];
    logic [7:0]  d_base;
    logic        j01;
    logic        j23;
    logic [15:0] e_div;
    logic [7:0]  e_ctrl;
    logic [3:0]  e_dist;
    logic [3:0]  f_dist;
    logic        e_change;
    logic        e_emit;
    logic [4:0]  e_plen;
    logic [24:0] product;
    logic        slot_free;
    logic        out_load;

    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DSR_W-1:0] div_divisor;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [DSR_W-1:0] div_rem;
    logic             pat_done;
    logic [30:0]      pat_bits;

    always_comb
    begin
        ctl = snap_reg[7:0];
        for (int i = 0; i < 4; i++)
        begin
            dv[i] = snap_reg[8*i+8 +: 8];
            cc[i] = snap_reg[8*i+40 +: 8];
        end
        d_base = ctl[0] ? DIV_15K : DIV_SLOW;
        j01 = ctl[4];
        j23 = ctl[3];
        dd[0] = ctl[6] ? DIV_FAST : d_base;
        mm[0] = ctl[6] ? OFS_FAST : OFS_NORMAL;
        dd[2] = ctl[5] ? DIV_FAST : d_base;
        mm[2] = ctl[5] ? OFS_FAST : OFS_NORMAL;
        dd[1] = j01 ? dd[0] : d_base;
        mm[1] = (j01 && dd[0] == DIV_FAST) ? OFS_JOINED : OFS_NORMAL;
        dd[3] = j23 ? dd[2] : d_base;
        mm[3] = (j23 && dd[2] == DIV_FAST) ? OFS_JOINED : OFS_NORMAL;
    end

    always_comb
    begin
        e_div = {8'h00, dv[ch_reg]};
        e_ctrl = cc[ch_reg];
        e_dist = cc[ch_reg][7:4];
        if (dv[ch_reg] <= 8'd1 && e_dist != DIST_PURE)
        begin
            e_ctrl[3:0] = 4'h0;
        end
        if ((j01 && !ch_reg[1]) || (j23 && ch_reg[1]))
        begin
            if (!ch_reg[0])
            begin
                e_ctrl[3:0] = 4'h0;
            end
            else
            begin
                e_div = {dv[ch_reg], dv[{ch_reg[1], 1'b0}]};
            end
        end
        e_change = prev_ctl_reg != ctl || prev_div_reg[ch_reg] != e_div ||
                   prev_cc_reg[ch_reg] != e_ctrl;
        e_emit = e_change && (e_ctrl[3:0] != 4'h0 || prev_cc_reg[ch_reg][3:0] != 4'h0);
        f_dist = e_dist;
        if (f_dist[0])
        begin
            f_dist = DIST_ODD;
        end
        if ((f_dist & DIST_PURE_A) == DIST_POLY5)
        begin
            f_dist = DIST_POLY5;
        end
        if ((f_dist & DIST_PURE_A) == DIST_PURE_A)
        begin
            f_dist = DIST_PURE_A;
        end
        if (f_dist == DIST_POLY4)
        begin
            e_plen = LEN_POLY4;
        end
        else if (f_dist == DIST_POLY5)
        begin
            e_plen = LEN_POLY5;
        end
        else
        begin
            e_plen = 5'd0;
        end
    end

    assign product = ({1'b0, cdiv_reg} + {14'd0, cm_reg}) * {17'd0, cd_reg};
    assign slot_free = !out_valid_reg || m_tready;
    assign out_load = pend_valid_reg && slot_free &&
                      (state_reg == S_PUSH || state_reg == S_END);

    always_comb
    begin
        div_start = state_reg == S_FSTART || state_reg == S_MSTART;
        if (state_reg == S_FSTART)
        begin
            div_dividend = DVD_W'(BASE_CLOCK) << FREQ_FRAC_BITS;
            div_divisor = {step_reg, 1'b0};
        end
        else
        begin
            div_dividend = DVD_W'(step_reg);
            div_divisor = DSR_W'(cplen_reg);
        end
    end

    srne_div #(.N(DVD_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    srne_pat u_pat (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_MWAIT && div_done),
        .size5  (cplen_reg == LEN_POLY5),
        .stride (div_rem[4:0]),
        .done   (pat_done),
        .bits   (pat_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            snap_reg <= '0;
            ch_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                prev_div_reg[i] <= '0;
                prev_cc_reg[i] <= '0;
            end
            prev_ctl_reg <= '0;
            cdiv_reg <= '0;
            cm_reg <= '0;
            cd_reg <= '0;
            cvol_reg <= '0;
            cdist_reg <= '0;
            cplen_reg <= '0;
            step_reg <= '0;
            freq_reg <= '0;
            pbits_reg <= '0;
            pend_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        snap_reg <= s_tdata;
                        ch_reg <= '0;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (e_change)
                    begin
                        prev_div_reg[ch_reg] <= e_div;
                        prev_cc_reg[ch_reg] <= e_ctrl;
                    end
                    cdiv_reg <= e_div;
                    cm_reg <= mm[ch_reg];
                    cd_reg <= dd[ch_reg];
                    cvol_reg <= e_ctrl[3:0];
                    cdist_reg <= f_dist;
                    cplen_reg <= e_plen;
                    if (e_emit)
                    begin
                        state_reg <= S_MUL;
                    end
                    else if (ch_reg == 2'd3)
                    begin
                        state_reg <= S_END;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                S_MUL:
                begin
                    step_reg <= product[STEP_W-1:0];
                    state_reg <= S_FSTART;
                end
                S_FSTART:
                begin
                    state_reg <= S_FWAIT;
                end
                S_FWAIT:
                begin
                    if (div_done)
                    begin
                        freq_reg <= (div_quo > DVD_W'(FREQ_MAX)) ? FREQ_MAX
                                                                 : div_quo[FREQ_W-1:0];
                        pbits_reg <= '0;
                        state_reg <= (cplen_reg == 5'd0) ? S_PUSH : S_MSTART;
                    end
                end
                S_MSTART:
                begin
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_PWAIT;
                    end
                end
                S_PWAIT:
                begin
                    if (pat_done)
                    begin
                        pbits_reg <= pat_bits;
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (slot_free || !pend_valid_reg)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg <= pend_reg;
                            out_last_reg <= 1'b0;
                        end
                        pend_reg.channel <= ch_reg;
                        pend_reg.hold <= cvol_reg != 4'h0;
                        pend_reg.frequency_q8 <= freq_reg;
                        pend_reg.volume <= cvol_reg;
                        pend_reg.distortion <= cdist_reg;
                        pend_reg.pattern_length <= cplen_reg;
                        pend_reg.pattern_bits <= pbits_reg;
                        pend_valid_reg <= 1'b1;
                        if (ch_reg == 2'd3)
                        begin
                            state_reg <= S_END;
                        end
                        else
                        begin
                            ch_reg <= ch_reg + 1'b1;
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_END:
                begin
                    if (!pend_valid_reg)
                    begin
                        prev_ctl_reg <= ctl;
                        state_reg <= S_IDLE;
                    end
                    else if (slot_free)
                    begin
                        out_reg <= pend_reg;
                        out_last_reg <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        prev_ctl_reg <= ctl;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {7'd0, out_reg};
    assign m_tlast = out_last_reg;

    a_idle_nothing_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("Event still pending while idle.");

    a_accept_starts_ch0: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_EVAL && ch_reg == 2'd0)
        else $error("Snapshot accept did not start at channel 0.");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_FWAIT || state_reg == S_MWAIT)
        else $error("Divider finished with no one waiting.");

    a_pat_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        pat_done |-> state_reg == S_PWAIT)
        else $error("Pattern walk finished with no one waiting.");

endmodule

// ===== tb/sv/tb_sound_register_to_note_events.sv =====
// Self-checking testbench for sound_register_to_note_events: drives register snapshots,
// predicts the note events in a scoreboard class and compares them field by field.
// Depends on srne_pkg and the sound_register_to_note_events RTL.
module tb_sound_register_to_note_events;
    timeunit 1ns;
    timeprecision 1ps;
    import srne_pkg::*;

    typedef struct {
        logic [1:0]  channel;
        logic        hold;
        logic [25:0] frequency_q8;
        logic [3:0]  volume;
        logic [3:0]  distortion;
        logic [4:0]  pattern_length;
        logic [30:0] pattern_bits;
        logic        last;
    } note_t;

    class note_scoreboard;
        logic [15:0] old_divider [4];
        logic [7:0]  old_ctrl [4];
        logic [7:0]  old_audio;
        note_t       pending [$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < 4; i++)
            begin
                old_divider[i] = '0;
                old_ctrl[i] = '0;
            end
            old_audio = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void sample_poly(int size, longint stride, output logic [4:0] len,
                                  output logic [30:0] bits);
            logic [30:0] seq;
            logic [31:0] lfsr;
            logic [31:0] acc;
            int          period;
            int          tap;
            int          pos;
            int          st;
            period = (1 << size) - 1;
            tap = (size == 4) ? 3 : 4;
            lfsr = 1;
            acc = 0;
            pos = 0;
            seq = '0;
            for (int i = 0; i < period; i++)
            begin
                seq[i] = ~lfsr[0];
                lfsr = ((lfsr << 1) & period) + (lfsr[2] ^ lfsr[tap]);
            end
            st = int'(stride % period);
            for (int i = 0; i < period; i++)
            begin
                acc = (acc << 1) | seq[pos];
                pos += st;
                if (pos >= period)
                    pos -= period;
            end
            while (acc != 0 && acc[0] == 0)
                acc = acc >> 1;
            len = 5'(period);
            bits = acc[30:0];
        endfunction

        function void note_snapshot(logic [71:0] snap);
            logic [7:0]  audio;
            logic [7:0]  dv [4];
            logic [7:0]  cc [4];
            int          clk_div [4];
            int          ofs [4];
            logic        j01;
            logic        j23;
            logic [15:0] div;
            logic [7:0]  ctrl;
            logic [3:0]  dist_code;
            logic [3:0]  vol;
            longint      freq;
            longint      period;
            note_t       ev;
            int          first;
            audio = snap[7:0];
            first = pending.size();
            for (int i = 0; i < 4; i++)
            begin
                dv[i] = snap[8 + 8*i +: 8];
                cc[i] = snap[40 + 8*i +: 8];
                clk_div[i] = int'(audio[0] ? DIV_15K : DIV_SLOW);
                ofs[i] = int'(OFS_NORMAL);
            end
            if (audio[6])
            begin
                clk_div[0] = int'(DIV_FAST);
                ofs[0] = int'(OFS_FAST);
            end
            if (audio[5])
            begin
                clk_div[2] = int'(DIV_FAST);
                ofs[2] = int'(OFS_FAST);
            end
            j01 = audio[4];
            j23 = audio[3];
            if (j01)
            begin
                clk_div[1] = clk_div[0];
                if (clk_div[1] == DIV_FAST)
                    ofs[1] = int'(OFS_JOINED);
            end
            if (j23)
            begin
                clk_div[3] = clk_div[2];
                if (clk_div[3] == DIV_FAST)
                    ofs[3] = int'(OFS_JOINED);
            end
            for (int i = 0; i < 4; i++)
            begin
                div = {8'd0, dv[i]};
                ctrl = cc[i];
                dist_code = cc[i][7:4];
                if (dv[i] <= 1 && dist_code != DIST_PURE)
                    ctrl[3:0] = 4'h0;
                if ((j01 && i < 2) || (j23 && i >= 2))
                begin
                    if (i % 2 == 0)
                        ctrl[3:0] = 4'h0;
                    else
                        div = {dv[i], dv[i-1]};
                end
                vol = ctrl[3:0];
                if (old_audio == audio && old_divider[i] == div && old_ctrl[i] == ctrl)
                    continue;
                if (vol == 0 && old_ctrl[i][3:0] == 0)
                begin
                    old_divider[i] = div;
                    old_ctrl[i] = ctrl;
                    continue;
                end
                old_divider[i] = div;
                old_ctrl[i] = ctrl;
                if (dist_code[0])
                    dist_code = DIST_ODD;
                if ((dist_code & 4'ha) == 4'h2)
                    dist_code = DIST_POLY5;
                if ((dist_code & 4'ha) == 4'ha)
                    dist_code = DIST_PURE_A;
                period = (longint'(div) + ofs[i]) * clk_div[i];
                ev.pattern_length = 0;
                ev.pattern_bits = 0;
                if (dist_code == DIST_POLY4)
                    sample_poly(4, period, ev.pattern_length, ev.pattern_bits);
                else if (dist_code == DIST_POLY5)
                    sample_poly(5, period, ev.pattern_length, ev.pattern_bits);
                freq = (longint'(BASE_CLOCK) << 8) / (2 * period);
                if (freq > longint'(FREQ_MAX))
                    freq = FREQ_MAX;
                ev.channel = 2'(i);
                ev.hold = (vol != 0);
                ev.frequency_q8 = freq[25:0];
                ev.volume = vol;
                ev.distortion = dist_code;
                ev.last = 0;
                pending.push_back(ev);
            end
            if (pending.size() > first)
                pending[pending.size() - 1].last = 1;
            old_audio = audio;
        endfunction

        function void check_note(logic [79:0] data, logic tl);
            note_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected note event %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[1:0] != e.channel)
            begin
                $error("channel exp %0d got %0d", e.channel, data[1:0]);
                errors++;
            end
            if (data[2] != e.hold)
            begin
                $error("hold exp %0d got %0d", e.hold, data[2]);
                errors++;
            end
            if (data[28:3] != e.frequency_q8)
            begin
                $error("frequency_q8 exp %0d got %0d", e.frequency_q8, data[28:3]);
                errors++;
            end
            if (data[32:29] != e.volume)
            begin
                $error("volume exp %0d got %0d", e.volume, data[32:29]);
                errors++;
            end
            if (data[36:33] != e.distortion)
            begin
                $error("distortion exp %h got %h", e.distortion, data[36:33]);
                errors++;
            end
            if (data[41:37] != e.pattern_length)
            begin
                $error("pattern_length exp %0d got %0d", e.pattern_length, data[41:37]);
                errors++;
            end
            if (data[72:42] != e.pattern_bits)
            begin
                $error("pattern_bits exp %h got %h", e.pattern_bits, data[72:42]);
                errors++;
            end
            if (tl != e.last)
            begin
                $error("last exp %0d got %0d", e.last, tl);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;

    note_scoreboard board;
    logic [71:0]    snaps [$];
    int             idle_cycles = 0;
    int             sent;
    bit             calm;
    int             hold_req;
    int             hold_seen;

    sound_register_to_note_events DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always
    begin
        clk = 0;
        #5;
        clk = 1;
        #5;
    end

    function automatic logic [7:0] pick_ctrl();
        logic [3:0] d;
        case ($urandom_range(0, 5))
            0: d = DIST_POLY4;
            1: d = DIST_POLY5;
            2: d = DIST_PURE;
            3: d = DIST_PURE_A;
            default: d = 4'($urandom_range(0, 15));
        endcase
        return {d, 4'($urandom_range(0, 15))};
    endfunction

    function automatic logic [71:0] random_snapshot();
        logic [71:0] s;
        s[7:0] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 4; i++)
        begin
            s[8 + 8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 2))
                                                           : 8'($urandom_range(0, 255));
            s[40 + 8*i +: 8] = pick_ctrl();
        end
        return s;
    endfunction

    task automatic send_snapshot(logic [71:0] s);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= s;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_snapshot(s);
        sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_note(m_tdata, m_tlast);
        if (rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        hold_seen = 0;
        m_tready <= 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_seen != hold_req)
            begin
                m_tready <= 0;
                repeat (600) @(posedge clk);
                hold_seen++;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [71:0] s;
        board = new();
        sent = 0;
        calm = 0;
        hold_req = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, clock modes, joins, degenerate dividers, silence.
        snaps = {
            {8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00},
            {8'hcf, 8'h2f, 8'h8f, 8'h1f, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00},
            {8'h8f, 8'ha5, 8'hc3, 8'h2f, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00},
            {8'h2f, 8'hcf, 8'ha8, 8'h8f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
            {8'hcf, 8'h2f, 8'h8f, 8'h1f, 8'h10, 8'h20, 8'h30, 8'h40, 8'h01},
            {8'hcf, 8'h2f, 8'h8f, 8'h1f, 8'h10, 8'h20, 8'h30, 8'h40, 8'h01},
            {8'hcf, 8'h2f, 8'h8f, 8'h1f, 8'h10, 8'h20, 8'h30, 8'h40, 8'h40},
            {8'hcf, 8'h2f, 8'h8f, 8'h1f, 8'h10, 8'h20, 8'h30, 8'h40, 8'h20},
            {8'hcf, 8'h2f, 8'h8f, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h18},
            {8'h2f, 8'hcf, 8'h2f, 8'hcf, 8'hff, 8'h00, 8'hff, 8'h00, 8'h78},
            {8'h2f, 8'hcf, 8'h2f, 8'hcf, 8'h01, 8'h00, 8'h01, 8'h00, 8'h79},
            {8'h2f, 8'hcf, 8'h2f, 8'hcf, 8'hff, 8'hff, 8'hff, 8'hff, 8'h19},
            {8'h5f, 8'h6f, 8'h7f, 8'h9f, 8'h80, 8'h40, 8'h20, 8'h10, 8'h86},
            {8'hb0, 8'hd0, 8'he0, 8'hf0, 8'h80, 8'h40, 8'h20, 8'h10, 8'h86},
            {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
            {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff}
        };
        foreach (snaps[k])
            send_snapshot(snaps[k]);

        // Fill the block while the receiver holds off.
        hold_req++;
        for (int k = 0; k < 10; k++)
            send_snapshot(random_snapshot());

        // Pause until every expected event has drained.
        s_tvalid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);

        for (int k = 0; k < 155; k++)
        begin
            if (k == 130)
                calm = 1;
            if ($urandom_range(0, 3) == 0)
            begin
                // Small change on top of the previous snapshot.
                s = s_tdata;
                s[8*$urandom_range(0, 8) +: 8] = ($urandom_range(0, 1)) ? pick_ctrl()
                                                 : 8'($urandom_range(0, 255));
            end
            else
                s = random_snapshot();
            send_snapshot(s);
        end
        s_tvalid <= 0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);

        $display("Sent %0d register snapshots, checked %0d note events,", sent, board.checked);
        $display("covering all clock modes, joins, muting and both polynomial patterns.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
